[rtl/core/mts_pkg.sv]
// package for the min tracking stack: depth, derived widths, codes and item types
// no dependencies
package mts_pkg;

  localparam int unsigned STACK_DEPTH = 64;
  localparam int unsigned CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int unsigned ADDR_W      = $clog2(STACK_DEPTH);
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned COUNT_OUT_W = 7;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    STATUS_DONE       = 2'd0,
    STATUS_PUSH_FULL  = 2'd1,
    STATUS_POP_EMPTY  = 2'd2
  } status_e;

  typedef struct packed {
    op_e                      op;
    logic signed [DATA_W-1:0] push_value;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] top_value;
    logic signed [DATA_W-1:0] min_value;
    logic [COUNT_OUT_W-1:0]   entry_count;
    logic                     is_empty;
    status_e                  status;
  } out_item_t;

  // one stored entry: value and the minimum up to and including it
  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] min;
  } entry_t;

endpackage

[rtl/core/min_tracking_stack_unit.sv]
// min tracking stack top level: entry memory, top-of-stack registers, output register
// depends on mts_pkg
//
//   channel | signals                              | direction
//   --------+--------------------------------------+----------
//   in      | in_valid_i, in_ready_o, in_item_i    | item in (op, push_value)
//   out     | out_valid_o, out_ready_i, out_item_o | item out (top, min, count, flags)
//
// a push or a rejected op is answered from the top-of-stack registers; a pop that
// uncovers a stored entry first reads the entry memory, then answers from S_POP_RD
// results leave through an output register; a new item is taken in the idle state when
// that register is empty or is emptied in the same cycle
// reset clears the count, the state machine and the output valid; the memory is not
// cleared, only entries below the count are ever read
module min_tracking_stack_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  mts_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output mts_pkg::out_item_t out_item_o
);
  import mts_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE   = 2'b01,
    S_POP_RD = 2'b10
  } state_e;

  // entry memory, one synchronous read port and one write port
  entry_t              mem [STACK_DEPTH];
  logic                mem_we;
  logic [ADDR_W-1:0]   mem_waddr;
  entry_t              mem_wdata;
  logic                mem_re;
  logic [ADDR_W-1:0]   mem_raddr;
  entry_t              rd_q;

  state_e              state_q, state_d;
  logic [CNT_W-1:0]    count_q, count_d;
  entry_t              top_q, top_d;          // copy of the top entry
  logic                out_valid_q, out_valid_d;
  out_item_t           out_item_q, out_item_d;

  logic                accept;
  logic                out_free;
  logic                is_full;
  logic                is_zero;
  logic [CNT_W-1:0]    cnt_m2;
  logic signed [DATA_W-1:0] new_min;

  // result fields built from a count and a top entry
  logic [CNT_W-1:0]    res_count;
  entry_t              res_top;
  status_e             res_status;
  logic [CNT_W+COUNT_OUT_W-1:0] count_ext;
  out_item_t           res_item;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE) && out_free;
  assign accept     = in_valid_i && in_ready_o;

  assign is_full = (count_q == CNT_W'(STACK_DEPTH));
  assign is_zero = (count_q == '0);
  assign cnt_m2  = count_q - CNT_W'(2);

  // the first entry is its own minimum, ties take the pushed value
  assign new_min = (!is_zero && (top_q.min < in_item_i.push_value)) ?
                   top_q.min : in_item_i.push_value;

  // count is truncated or zero-extended to the output field
  assign count_ext = {{COUNT_OUT_W{1'b0}}, res_count};

  always_comb begin
    res_item.top_value   = (res_count == '0) ? '0 : res_top.value;
    res_item.min_value   = (res_count == '0) ? '0 : res_top.min;
    res_item.entry_count = count_ext[COUNT_OUT_W-1:0];
    res_item.is_empty    = (res_count == '0);
    res_item.status      = res_status;
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    top_d       = top_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_item_d  = out_item_q;
    mem_we      = 1'b0;
    mem_waddr   = count_q[ADDR_W-1:0];
    mem_wdata   = '{value: in_item_i.push_value, min: new_min};
    mem_re      = 1'b0;
    mem_raddr   = cnt_m2[ADDR_W-1:0];
    res_count   = count_q;
    res_top     = top_q;
    res_status  = STATUS_DONE;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (in_item_i.op == OP_PUSH) begin
            if (is_full) begin
              res_status = STATUS_PUSH_FULL;
            end else begin
              mem_we    = 1'b1;
              top_d     = mem_wdata;
              count_d   = count_q + CNT_W'(1);
              res_count = count_d;
              res_top   = mem_wdata;
            end
            out_valid_d = 1'b1;
            out_item_d  = res_item;
          end else begin
            if (is_zero) begin
              res_status  = STATUS_POP_EMPTY;
              out_valid_d = 1'b1;
              out_item_d  = res_item;
            end else if (count_q == CNT_W'(1)) begin
              // last entry leaves, nothing to fetch
              count_d     = '0;
              res_count   = '0;
              out_valid_d = 1'b1;
              out_item_d  = res_item;
            end else begin
              // fetch the entry below the top into the read register, S_POP_RD builds the result
              mem_re  = 1'b1;
              count_d = count_q - CNT_W'(1);
              state_d = S_POP_RD;
            end
          end
        end
      end
      S_POP_RD: begin
        // output register is empty here: the pop was taken only when it was free
        top_d       = rd_q;
        res_top     = rd_q;
        out_valid_d = 1'b1;
        out_item_d  = res_item;
        state_d     = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    top_q      <= top_d;
    out_item_q <= out_item_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule
